@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ rtl/teq_pkg.sv @@
`timescale 1ns / 1ps
package teq_pkg;

  localparam logic [4:0] REQ_ADVANCE     = 5'd0;
  localparam logic [4:0] REQ_SCHEDULE    = 5'd1;
  localparam logic [4:0] REQ_RESCHEDULE  = 5'd2;
  localparam logic [4:0] REQ_CANCEL      = 5'd3;
  localparam logic [4:0] REQ_CANCEL_GRP  = 5'd4;
  localparam logic [4:0] REQ_EXECUTE     = 5'd5;
  localparam logic [4:0] REQ_PEEK        = 5'd6;
  localparam logic [4:0] REQ_POP         = 5'd7;
  localparam logic [4:0] REQ_REPEAT      = 5'd8;
  localparam logic [4:0] REQ_PHASE_SET   = 5'd9;
  localparam logic [4:0] REQ_PHASE_ADD   = 5'd10;
  localparam logic [4:0] REQ_PHASE_DEL   = 5'd11;
  localparam logic [4:0] REQ_DELAY_ALL   = 5'd12;
  localparam logic [4:0] REQ_DELAY_EVENT = 5'd13;
  localparam logic [4:0] REQ_DELAY_GROUP = 5'd14;
  localparam logic [4:0] REQ_QUERY       = 5'd15;
  localparam logic [4:0] REQ_RECALC      = 5'd16;

  localparam logic [1:0] SCAN_SURVEY     = 2'd0;
  localparam logic [1:0] SCAN_CANCEL_ID  = 2'd1;
  localparam logic [1:0] SCAN_CANCEL_GRP = 2'd2;
  localparam logic [1:0] SCAN_MARK       = 2'd3;

  localparam logic [1:0] TL_NONE   = 2'd0;
  localparam logic [1:0] TL_SCHED  = 2'd1;
  localparam logic [1:0] TL_RECALC = 2'd2;
  localparam logic [1:0] TL_DELAY  = 2'd3;

  localparam logic [1:0] CAP_NONE = 2'd0;
  localparam logic [1:0] CAP_NEW  = 2'd1;
  localparam logic [1:0] CAP_HEAD = 2'd2;
  localparam logic [1:0] CAP_PEND = 2'd3;

  typedef struct packed {
    logic [31:0] due;
    logic [15:0] ev_id;
    logic [7:0]  groups;
    logic [7:0]  phases;
  } entry_t;

  typedef struct packed {
    logic       accept;
    logic       scan_start;
    logic [1:0] scan_mode;
    logic       simple;
    logic [1:0] t_load;
    logic       t_inc;
    logic [1:0] cap;
    logic       write;
    logic       clr_head;
    logic       clr_pend;
    logic       take;
    logic       query;
    logic       set_full;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [4:0] req;
    logic       done;
    logic       free_found;
    logic       head_found;
    logic       head_late;
    logic       head_skip;
    logic       first_found;
    logic       recalc_ok;
    logic       taken;
    logic       pend_found;
  } stat_t;

  function automatic logic [7:0] group_bit(input logic [3:0] g);
    group_bit = (g >= 4'd1 && g <= 4'd8) ? (8'd1 << (g - 4'd1)) : 8'd0;
  endfunction

endpackage

@@ rtl/teq_dp.sv @@
`timescale 1ns / 1ps
module teq_dp #(
  parameter int DEPTH = 32,
  parameter int NUM_PHASES = 8,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  teq_pkg::cmd_t      cmd,
  output teq_pkg::stat_t     stat,
  input  logic [4:0]         req_type,
  input  logic [15:0]        event_id,
  input  logic [31:0]        amount,
  input  logic [3:0]         group,
  input  logic [3:0]         phase,
  input  logic signed [31:0] min_time,
  input  logic               add_remaining,
  output logic [15:0]        result_event,
  output logic               found,
  output logic [31:0]        event_time,
  output logic [31:0]        current_time,
  output logic [7:0]         phase_state,
  output logic               table_full
);

  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  logic [4:0]         req;
  logic [15:0]        id_q;
  logic [31:0]        amount_q;
  logic [3:0]         group_q;
  logic [3:0]         phase_q;
  logic signed [31:0] min_q;
  logic               addrem_q;

  teq_pkg::entry_t    mem [DEPTH];
  teq_pkg::entry_t    rd_q;
  logic [DEPTH-1:0]   valid;
  logic [DEPTH-1:0]   pending;
  logic [31:0]        now_time;
  logic [7:0]         active;

  logic               scan_run;
  logic [IW-1:0]      scan_idx;
  logic               s1;
  logic [IW-1:0]      s1_idx;
  logic               s1_last;
  logic [1:0]         mode;
  logic               done_q;

  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic               head_found;
  logic [IW-1:0]      head_idx;
  teq_pkg::entry_t    head_ent;
  logic               first_found;
  logic [31:0]        first_due;
  logic               taken;
  logic               pend_found;
  logic [IW-1:0]      pend_idx;
  teq_pkg::entry_t    pend_ent;

  logic [31:0]        t_reg;
  logic [IW-1:0]      wr_idx;
  teq_pkg::entry_t    wr_ent;

  logic [15:0]        res_event;
  logic               res_found;
  logic [31:0]        res_time;
  logic               res_full;

  logic [7:0]         gmask;
  logic [7:0]         pmask;
  logic [31:0]        limit;
  logic [31:0]        remu;
  logic               v;
  logic               id_hit;
  logic               mark_hit;

  function automatic logic [7:0] phase_bit(input logic [3:0] p);
    phase_bit = (p >= 4'd1 && int'(p) <= NUM_PHASES) ? (8'd1 << (p - 4'd1)) : 8'd0;
  endfunction

  assign gmask    = teq_pkg::group_bit(group_q);
  assign pmask    = phase_bit(phase_q);
  assign limit    = now_time + amount_q;
  assign remu     = first_due - now_time;
  assign v        = valid[s1_idx];
  assign id_hit   = rd_q.ev_id == id_q;
  assign mark_hit = (req == teq_pkg::REQ_DELAY_GROUP) ? ((rd_q.groups & gmask) != 8'd0)
                                                      : id_hit;

  always_comb begin
    stat.req         = req;
    stat.done        = done_q;
    stat.free_found  = free_found;
    stat.head_found  = head_found;
    stat.head_late   = head_ent.due > now_time;
    stat.head_skip   = (active != 8'd0) && (head_ent.phases != 8'd0) &&
                       ((head_ent.phases & active) == 8'd0);
    stat.first_found = first_found;
    stat.recalc_ok   = $signed(remu) < min_q;
    stat.taken       = taken;
    stat.pend_found  = pend_found;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req      <= req_type;
      id_q     <= event_id;
      amount_q <= amount;
      group_q  <= group;
      phase_q  <= phase;
      min_q    <= min_time;
      addrem_q <= add_remaining;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[scan_idx];
    if (cmd.write) begin
      mem[wr_idx] <= '{due: t_reg, ev_id: wr_ent.ev_id, groups: wr_ent.groups,
                       phases: wr_ent.phases};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_run <= 1'b0;
      scan_idx <= '0;
      s1       <= 1'b0;
      s1_idx   <= '0;
      s1_last  <= 1'b0;
      mode     <= teq_pkg::SCAN_SURVEY;
      done_q   <= 1'b0;
    end else begin
      done_q  <= s1 && s1_last;
      s1      <= scan_run;
      s1_idx  <= scan_idx;
      s1_last <= scan_idx == LAST;
      if (cmd.scan_start) begin
        scan_run <= 1'b1;
        scan_idx <= '0;
        mode     <= cmd.scan_mode;
      end else if (scan_run) begin
        if (scan_idx == LAST) begin
          scan_run <= 1'b0;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (s1 && mode == teq_pkg::SCAN_CANCEL_ID && v && id_hit) begin
        valid[s1_idx] <= 1'b0;
      end
      if (s1 && mode == teq_pkg::SCAN_CANCEL_GRP && v && ((rd_q.groups & gmask) != 8'd0)) begin
        valid[s1_idx] <= 1'b0;
      end
      if (cmd.clr_head) begin
        valid[head_idx] <= 1'b0;
      end
      if (cmd.write) begin
        valid[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      if (s1 && mode == teq_pkg::SCAN_MARK) begin
        pending[s1_idx] <= v && (rd_q.due < limit) && mark_hit;
      end
      if (cmd.clr_pend) begin
        pending[pend_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_found  <= 1'b0;
      head_found  <= 1'b0;
      first_found <= 1'b0;
      taken       <= 1'b0;
      pend_found  <= 1'b0;
    end else if (cmd.scan_start) begin
      free_found  <= 1'b0;
      head_found  <= 1'b0;
      first_found <= 1'b0;
      taken       <= 1'b0;
      pend_found  <= 1'b0;
    end else if (s1) begin
      if (!v && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= s1_idx;
      end
      if (v && (!head_found || rd_q.due < head_ent.due)) begin
        head_found <= 1'b1;
        head_idx   <= s1_idx;
        head_ent   <= rd_q;
      end
      if (v && id_hit && (!first_found || rd_q.due < first_due)) begin
        first_found <= 1'b1;
        first_due   <= rd_q.due;
      end
      if (v && rd_q.due == t_reg) begin
        taken <= 1'b1;
      end
      if (pending[s1_idx] && (!pend_found || rd_q.due < pend_ent.due)) begin
        pend_found <= 1'b1;
        pend_idx   <= s1_idx;
        pend_ent   <= rd_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.t_load)
      teq_pkg::TL_SCHED:  t_reg <= now_time + amount_q;
      teq_pkg::TL_RECALC: t_reg <= addrem_q ? (min_q + first_due) : (now_time + min_q);
      teq_pkg::TL_DELAY:  t_reg <= pend_ent.due + amount_q;
      default: begin
        if (cmd.t_inc) begin
          t_reg <= t_reg + 32'd1;
        end
      end
    endcase
    case (cmd.cap)
      teq_pkg::CAP_NEW: begin
        wr_idx <= free_idx;
        wr_ent <= '{due: 32'd0, ev_id: id_q,
                    groups: (req == teq_pkg::REQ_RECALC) ? 8'd0 : gmask,
                    phases: (req == teq_pkg::REQ_RECALC) ? 8'd0 : pmask};
      end
      teq_pkg::CAP_HEAD: begin
        wr_idx <= head_idx;
        wr_ent <= head_ent;
      end
      teq_pkg::CAP_PEND: begin
        wr_idx <= pend_idx;
        wr_ent <= pend_ent;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_time <= 32'd0;
      active   <= 8'd0;
    end else if (cmd.simple) begin
      case (req)
        teq_pkg::REQ_ADVANCE:   now_time <= now_time + amount_q;
        teq_pkg::REQ_DELAY_ALL: now_time <= (amount_q < now_time) ? now_time - amount_q : 32'd0;
        teq_pkg::REQ_PHASE_SET: begin
          if (phase_q == 4'd0) begin
            active <= 8'd0;
          end else if (pmask != 8'd0) begin
            active <= pmask;
          end
        end
        teq_pkg::REQ_PHASE_ADD: active <= active | pmask;
        teq_pkg::REQ_PHASE_DEL: active <= active & ~pmask;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_event <= 16'd0;
      res_found <= 1'b0;
      res_time  <= 32'd0;
      res_full  <= 1'b0;
    end else begin
      if (cmd.take) begin
        res_event <= head_ent.ev_id;
        res_found <= 1'b1;
      end
      if (cmd.query) begin
        res_found <= 1'b1;
        res_time  <= first_due;
      end
      if (cmd.set_full) begin
        res_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_event <= res_event;
      found        <= res_found;
      event_time   <= res_time;
      current_time <= now_time;
      phase_state  <= active;
      table_full   <= res_full;
    end
  end

endmodule

@@ rtl/teq_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module teq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output teq_pkg::cmd_t  cmd,
  input  teq_pkg::stat_t stat
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_EXEC      = 4'd1;
  localparam logic [3:0] ST_SCAN      = 4'd2;
  localparam logic [3:0] ST_ADD_FIND  = 4'd3;
  localparam logic [3:0] ST_ADD       = 4'd4;
  localparam logic [3:0] ST_PROBE_CHK = 4'd5;
  localparam logic [3:0] ST_WRITE     = 4'd6;
  localparam logic [3:0] ST_DECIDE    = 4'd7;
  localparam logic [3:0] ST_PICK      = 4'd8;
  localparam logic [3:0] ST_DELAY     = 4'd9;
  localparam logic [3:0] ST_DONE      = 4'd10;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;
  logic [1:0] mode, mode_next;
  logic       busy, busy_next;
  logic       out_valid_next;

  assign in_stall = state != ST_IDLE;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    ret_next       = ret;
    mode_next      = mode;
    busy_next      = busy;
    cmd.accept     = in_valid && (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.req)
          teq_pkg::REQ_ADVANCE, teq_pkg::REQ_DELAY_ALL, teq_pkg::REQ_PHASE_SET,
          teq_pkg::REQ_PHASE_ADD, teq_pkg::REQ_PHASE_DEL: begin
            cmd.simple = 1'b1;
            state_next = ST_DONE;
          end
          teq_pkg::REQ_SCHEDULE: begin
            mode_next  = teq_pkg::SCAN_SURVEY;
            ret_next   = ST_ADD;
            state_next = ST_SCAN;
          end
          teq_pkg::REQ_RESCHEDULE: begin
            mode_next  = teq_pkg::SCAN_CANCEL_ID;
            ret_next   = ST_ADD_FIND;
            state_next = ST_SCAN;
          end
          teq_pkg::REQ_CANCEL: begin
            mode_next  = teq_pkg::SCAN_CANCEL_ID;
            ret_next   = ST_DONE;
            state_next = ST_SCAN;
          end
          teq_pkg::REQ_CANCEL_GRP: begin
            mode_next  = teq_pkg::SCAN_CANCEL_GRP;
            ret_next   = ST_DONE;
            state_next = ST_SCAN;
          end
          teq_pkg::REQ_EXECUTE, teq_pkg::REQ_PEEK, teq_pkg::REQ_POP, teq_pkg::REQ_REPEAT,
          teq_pkg::REQ_QUERY, teq_pkg::REQ_RECALC: begin
            mode_next  = teq_pkg::SCAN_SURVEY;
            ret_next   = ST_DECIDE;
            state_next = ST_SCAN;
          end
          teq_pkg::REQ_DELAY_EVENT, teq_pkg::REQ_DELAY_GROUP: begin
            mode_next  = teq_pkg::SCAN_MARK;
            ret_next   = ST_PICK;
            state_next = ST_SCAN;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (!busy) begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = mode;
          busy_next      = 1'b1;
        end else if (stat.done) begin
          busy_next  = 1'b0;
          state_next = ret;
        end
      end
      ST_ADD_FIND: begin
        mode_next  = teq_pkg::SCAN_SURVEY;
        ret_next   = ST_ADD;
        state_next = ST_SCAN;
      end
      ST_ADD: begin
        if (!stat.free_found) begin
          cmd.set_full = 1'b1;
          state_next   = ST_DONE;
        end else begin
          cmd.cap = teq_pkg::CAP_NEW;
          if (stat.req != teq_pkg::REQ_RECALC) begin
            cmd.t_load = teq_pkg::TL_SCHED;
          end
          mode_next  = teq_pkg::SCAN_SURVEY;
          ret_next   = ST_PROBE_CHK;
          state_next = ST_SCAN;
        end
      end
      ST_PROBE_CHK: begin
        if (stat.taken) begin
          cmd.t_inc  = 1'b1;
          mode_next  = teq_pkg::SCAN_SURVEY;
          ret_next   = ST_PROBE_CHK;
          state_next = ST_SCAN;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        if (stat.req == teq_pkg::REQ_DELAY_EVENT || stat.req == teq_pkg::REQ_DELAY_GROUP) begin
          state_next = ST_PICK;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_PICK: begin
        mode_next  = teq_pkg::SCAN_SURVEY;
        ret_next   = ST_DELAY;
        state_next = ST_SCAN;
      end
      ST_DELAY: begin
        if (!stat.pend_found) begin
          state_next = ST_DONE;
        end else begin
          cmd.clr_pend = 1'b1;
          cmd.cap      = teq_pkg::CAP_PEND;
          cmd.t_load   = teq_pkg::TL_DELAY;
          mode_next    = teq_pkg::SCAN_SURVEY;
          ret_next     = ST_PROBE_CHK;
          state_next   = ST_SCAN;
        end
      end
      ST_DECIDE: begin
        state_next = ST_DONE;
        case (stat.req)
          teq_pkg::REQ_EXECUTE, teq_pkg::REQ_PEEK: begin
            if (stat.head_found && !stat.head_late) begin
              if (stat.head_skip) begin
                cmd.clr_head = 1'b1;
                mode_next    = teq_pkg::SCAN_SURVEY;
                ret_next     = ST_DECIDE;
                state_next   = ST_SCAN;
              end else begin
                cmd.take     = 1'b1;
                cmd.clr_head = stat.req == teq_pkg::REQ_EXECUTE;
              end
            end
          end
          teq_pkg::REQ_POP: begin
            if (stat.head_found) begin
              cmd.take     = 1'b1;
              cmd.clr_head = 1'b1;
            end
          end
          teq_pkg::REQ_REPEAT: begin
            if (stat.head_found) begin
              cmd.clr_head = 1'b1;
              cmd.cap      = teq_pkg::CAP_HEAD;
              cmd.t_load   = teq_pkg::TL_SCHED;
              mode_next    = teq_pkg::SCAN_SURVEY;
              ret_next     = ST_PROBE_CHK;
              state_next   = ST_SCAN;
            end
          end
          teq_pkg::REQ_QUERY: begin
            cmd.query = stat.first_found;
          end
          teq_pkg::REQ_RECALC: begin
            if (stat.first_found && stat.recalc_ok) begin
              cmd.t_load = teq_pkg::TL_RECALC;
              mode_next  = teq_pkg::SCAN_CANCEL_ID;
              ret_next   = ST_ADD_FIND;
              state_next = ST_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      mode      <= teq_pkg::SCAN_SURVEY;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      mode      <= mode_next;
      busy      <= busy_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_CLK(a_done_in_scan, clk, rst, stat.done |-> (state == ST_SCAN && busy))
  `ASSERT_NEVER(a_busy_outside_scan, clk, rst, busy && state != ST_SCAN)
  `ASSERT_CLK(a_accept_dispatch, clk, rst, cmd.accept |=> state == ST_EXEC)

endmodule

@@ rtl/timed_event_queue.sv @@
`timescale 1ns / 1ps
// Timed event queue. One request is taken at a time and gives exactly one result.
// Work is done by full passes over the DEPTH-entry table, one entry per cycle
// through the single read port of the entry memory. Timer and phase requests need
// no pass; cancel, query, pop, peek and execute take one pass (execute and peek
// one more per entry dropped by the phase filter); schedule and repeat take 2 + k
// passes, where k is the number of due-time collisions bumped past; reschedule
// takes one more and recalc two more when it moves the event; event and group
// delays take 2 passes plus 2 + k passes per moved entry.
// A finished result sits in the output register while the next request is taken.
// No clearing pass is needed after reset.
module timed_event_queue #(
  parameter int DEPTH = 32,
  parameter int NUM_PHASES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         req_type,
  input  logic [15:0]        event_id,
  input  logic [31:0]        amount,
  input  logic [3:0]         group,
  input  logic [3:0]         phase,
  input  logic signed [31:0] min_time,
  input  logic               add_remaining,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        result_event,
  output logic               found,
  output logic [31:0]        event_time,
  output logic [31:0]        current_time,
  output logic [7:0]         phase_state,
  output logic               table_full
);

  teq_pkg::cmd_t  cmd;
  teq_pkg::stat_t stat;

  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  teq_dp #(
    .DEPTH      (DEPTH),
    .NUM_PHASES (NUM_PHASES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .event_id      (event_id),
    .amount        (amount),
    .group         (group),
    .phase         (phase),
    .min_time      (min_time),
    .add_remaining (add_remaining),
    .result_event  (result_event),
    .found         (found),
    .event_time    (event_time),
    .current_time  (current_time),
    .phase_state   (phase_state),
    .table_full    (table_full)
  );

endmodule
